### rtl/dtt_pkg.sv
// dtt_pkg: shared types, function codes and the sequencer microprogram
// for the deadline timer table; depends on nothing else
package dtt_pkg;

    localparam int unsigned MaxSlotsDefault = 16;
    localparam int unsigned FuncW           = 3;
    localparam int unsigned TagW            = 8;
    localparam int unsigned TimeW           = 64;

    localparam logic [TimeW-1:0] NEVER_TIME = '1;

    // function codes of a request
    localparam logic [FuncW-1:0] FN_REGISTER   = 3'd0;
    localparam logic [FuncW-1:0] FN_ARM        = 3'd1;
    localparam logic [FuncW-1:0] FN_DISARM     = 3'd2;
    localparam logic [FuncW-1:0] FN_DISARM_ALL = 3'd3;
    localparam logic [FuncW-1:0] FN_QUERY      = 3'd4;
    localparam logic [FuncW-1:0] FN_SOONEST    = 3'd5;
    localparam logic [FuncW-1:0] FN_TAKE       = 3'd6;
    localparam logic [FuncW-1:0] FN_RESERVED   = 3'd7;

    // datapath operation of a microstep
    typedef enum logic [3:0] {
        UOP_WAIT  = 4'b0001,
        UOP_SETUP = 4'b0010,
        UOP_SCAN  = 4'b0100,
        UOP_APPLY = 4'b1000
    } t_uop;

    // jump condition of a microstep
    typedef enum logic [3:0] {
        COND_NOT_ACCEPT = 4'b0001,
        COND_SKIP_SCAN  = 4'b0010,
        COND_SCAN_BUSY  = 4'b0100,
        COND_OUT_FULL   = 4'b1000
    } t_cond;

    localparam int unsigned StepW = 2;
    typedef logic [StepW-1:0] t_step;

    localparam t_step STEP_WAIT  = 2'd0;
    localparam t_step STEP_SETUP = 2'd1;
    localparam t_step STEP_SCAN  = 2'd2;
    localparam t_step STEP_APPLY = 2'd3;

    // one control word: taken jump goes to jump, otherwise to next
    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_step jump;
        t_step next;
    } t_uword;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic accept;
        logic skip_scan;
        logic scan_busy;
        logic out_full;
    } t_status;

    localparam t_uword UPROG [4] = '{
        '{uop: UOP_WAIT,  cond: COND_NOT_ACCEPT, jump: STEP_WAIT,  next: STEP_SETUP},
        '{uop: UOP_SETUP, cond: COND_SKIP_SCAN,  jump: STEP_APPLY, next: STEP_SCAN},
        '{uop: UOP_SCAN,  cond: COND_SCAN_BUSY,  jump: STEP_SCAN,  next: STEP_APPLY},
        '{uop: UOP_APPLY, cond: COND_OUT_FULL,   jump: STEP_APPLY, next: STEP_WAIT}
    };

endpackage

### rtl/dtt_if.sv
// dtt_req_if and dtt_rsp_if: valid/ready channels of the timer table
// depends on dtt_pkg
interface dtt_req_if import dtt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [FuncW-1:0] func;
    logic [TagW-1:0]  tag;
    logic [TimeW-1:0] time_value;

    modport source(output valid, func, tag, time_value, input ready);
    modport sink(input valid, func, tag, time_value, output ready);
endinterface

interface dtt_rsp_if import dtt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [TagW-1:0]  fired_tag;
    logic [TimeW-1:0] result_time;

    modport source(output valid, ok, fired_tag, result_time, input ready);
    modport sink(input valid, ok, fired_tag, result_time, output ready);
endinterface

### rtl/dtt_seq.sv
// dtt_seq: step counter and microprogram table of the timer table
// depends on dtt_pkg
module dtt_seq import dtt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_uword  o_uword
);

    t_step r_step, n_step;
    logic  cond_true;

    assign o_uword = UPROG[r_step];

    always_comb begin
        unique case (o_uword.cond)
            COND_NOT_ACCEPT: cond_true = ~i_status.accept;
            COND_SKIP_SCAN:  cond_true = i_status.skip_scan;
            COND_SCAN_BUSY:  cond_true = i_status.scan_busy;
            COND_OUT_FULL:   cond_true = i_status.out_full;
            default:         cond_true = 1'b0;
        endcase
        n_step = cond_true ? o_uword.jump : o_uword.next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### rtl/dtt_datapath.sv
// dtt_datapath: slot memories, armed flags, scan comparators and result register
// depends on dtt_pkg and dtt_if; driven by control words from dtt_seq
module dtt_datapath import dtt_pkg::*; #(
    parameter int unsigned MAX_SLOTS = MaxSlotsDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtt_req_if.sink       i_req,
    dtt_rsp_if.source     o_rsp,
    input  t_uword        i_uword,
    output t_status       o_status
);

    localparam int unsigned IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned CntW = $clog2(MAX_SLOTS + 1);
    localparam logic [CntW-1:0] SlotsMax = CntW'(MAX_SLOTS);

    // slot storage
    logic [TagW-1:0]  mem_tag [MAX_SLOTS];
    logic [TimeW-1:0] mem_dl  [MAX_SLOTS];
    logic [TagW-1:0]  r_rd_tag;
    logic [TimeW-1:0] r_rd_dl;

    // control state
    logic [CntW-1:0]      r_used;
    logic [MAX_SLOTS-1:0] r_armed, n_armed;
    logic [TimeW-1:0]     r_dispatch;
    logic                 r_handler;
    logic                 r_out_valid;

    // captured request
    logic [FuncW-1:0] r_func;
    logic [TagW-1:0]  r_tag;
    logic [TimeW-1:0] r_tv;

    // scan state
    logic [CntW-1:0]  r_idx;
    logic             r_pv;
    logic [IdxW-1:0]  r_pidx;
    logic             r_found;
    logic [IdxW-1:0]  r_hit;
    logic [IdxW-1:0]  r_take;
    logic [TimeW-1:0] r_best;
    logic             r_best_ok;
    logic [TagW-1:0]  r_best_tag;

    // result payload
    logic             r_out_ok;
    logic [TagW-1:0]  r_out_fired;
    logic [TimeW-1:0] r_out_time;

    logic accept, scan_issue, out_full, do_setup, do_scan, do_apply;
    logic rd_armed, rd_match, dl_lt, dl_le;

    // apply decode
    logic             ap_ok;
    logic [TagW-1:0]  ap_fired;
    logic [TimeW-1:0] ap_time;
    logic             tag_we, dl_we, used_inc, handler_set;
    logic [IdxW-1:0]  w_addr;
    logic [TimeW-1:0] w_dl;

    assign i_req.ready = (i_uword.uop == UOP_WAIT) & i_rst_n;
    assign accept      = i_req.valid & i_req.ready;
    assign scan_issue  = (r_idx < r_used);
    assign out_full    = r_out_valid & ~o_rsp.ready;
    assign do_setup    = (i_uword.uop == UOP_SETUP);
    assign do_scan     = (i_uword.uop == UOP_SCAN);
    assign do_apply    = (i_uword.uop == UOP_APPLY) & ~out_full;

    assign o_status.accept    = accept;
    assign o_status.skip_scan = (r_func == FN_DISARM_ALL) | (r_func == FN_RESERVED);
    assign o_status.scan_busy = scan_issue | r_pv;
    assign o_status.out_full  = out_full;

    assign rd_armed = r_armed[r_pidx];
    assign rd_match = (r_rd_tag == r_tag);
    assign dl_lt    = (r_rd_dl < r_best);
    assign dl_le    = (r_rd_dl <= r_tv);

    always_comb begin
        ap_ok       = 1'b0;
        ap_fired    = '0;
        ap_time     = '0;
        tag_we      = 1'b0;
        dl_we       = 1'b0;
        used_inc    = 1'b0;
        handler_set = 1'b0;
        w_addr      = r_hit;
        w_dl        = r_tv;
        n_armed     = r_armed;
        unique case (r_func)
            FN_REGISTER: begin
                w_addr = r_used[IdxW-1:0];
                w_dl   = '0;
                if (r_used < SlotsMax && !r_found) begin
                    tag_we          = 1'b1;
                    dl_we           = 1'b1;
                    used_inc        = 1'b1;
                    n_armed[w_addr] = 1'b0;
                    ap_ok           = 1'b1;
                end
            end
            FN_ARM: begin
                if (r_found && !(r_handler && r_tv <= r_dispatch)) begin
                    dl_we          = 1'b1;
                    n_armed[r_hit] = 1'b1;
                    ap_ok          = 1'b1;
                end
            end
            FN_DISARM: begin
                if (r_found) begin
                    n_armed[r_hit] = 1'b0;
                    ap_ok          = 1'b1;
                end
            end
            FN_DISARM_ALL: begin
                n_armed = '0;
                ap_ok   = 1'b1;
            end
            FN_QUERY: begin
                ap_ok   = 1'b1;
                ap_time = (r_found && r_armed[r_hit]) ? r_best : NEVER_TIME;
            end
            FN_SOONEST: begin
                ap_ok   = 1'b1;
                ap_time = r_best;
            end
            FN_TAKE: begin
                if (r_best_ok) begin
                    handler_set     = 1'b1;
                    n_armed[r_take] = 1'b0;
                    ap_ok           = 1'b1;
                    ap_fired        = r_best_tag;
                    ap_time         = r_best;
                end else begin
                    ap_time = NEVER_TIME;
                end
            end
            default: begin
            end
        endcase
    end

    // slot memories: one write port, one registered read port at the scan index
    always_ff @(posedge i_clk) begin
        if (do_apply && tag_we) begin
            mem_tag[w_addr] <= r_tag;
        end
        if (do_apply && dl_we) begin
            mem_dl[w_addr] <= w_dl;
        end
        r_rd_tag <= mem_tag[r_idx[IdxW-1:0]];
        r_rd_dl  <= mem_dl[r_idx[IdxW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_armed     <= '0;
            r_dispatch  <= '0;
            r_handler   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (do_setup) begin
                r_idx <= '0;
                r_pv  <= 1'b0;
            end else if (do_scan) begin
                r_pv <= scan_issue;
                if (scan_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (do_apply) begin
                r_armed     <= n_armed;
                r_out_valid <= 1'b1;
                if (used_inc) begin
                    r_used <= r_used + 1'b1;
                end
                if (r_func == FN_TAKE) begin
                    r_handler <= handler_set;
                end
                if (handler_set) begin
                    r_dispatch <= r_best;
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture, scan results and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_req.func;
            r_tag  <= i_req.tag;
            r_tv   <= i_req.time_value;
        end
        // slot index that the read port data belongs to on the next cycle
        if (do_scan && scan_issue) begin
            r_pidx <= r_idx[IdxW-1:0];
        end
        if (do_setup) begin
            r_found   <= 1'b0;
            r_best    <= NEVER_TIME;
            r_best_ok <= 1'b0;
        end else if (do_scan && r_pv) begin
            if (rd_match && !r_found) begin
                r_found <= 1'b1;
                r_hit   <= r_pidx;
                if (r_func == FN_QUERY) begin
                    r_best <= r_rd_dl;
                end
            end
            if (r_func == FN_SOONEST && rd_armed && dl_lt) begin
                r_best <= r_rd_dl;
            end
            if (r_func == FN_TAKE && rd_armed && dl_le && (!r_best_ok || dl_lt)) begin
                r_best     <= r_rd_dl;
                r_best_ok  <= 1'b1;
                r_take     <= r_pidx;
                r_best_tag <= r_rd_tag;
            end
        end
        if (do_apply) begin
            r_out_ok    <= ap_ok;
            r_out_fired <= ap_fired;
            r_out_time  <= ap_time;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_out_ok;
    assign o_rsp.fired_tag   = r_out_fired;
    assign o_rsp.result_time = r_out_time;

endmodule

### rtl/deadline_timer_table.sv
// deadline_timer_table: top level of the earliest-deadline timer table
// depends on dtt_pkg, dtt_if, dtt_seq and dtt_datapath
//
//   channel  dir  modport  payload                               request taken when
//   i_req    in   sink     func[2:0] tag[7:0] time_value[63:0]   valid && ready
//   o_rsp    out  source   ok fired_tag[7:0] result_time[63:0]   valid && ready
//
// one request at a time; from acceptance a request passes the scan setup, the scan and the
// result step, and disarm all and the reserved code skip the scan; the scan walks the used
// slots of the slot memory one entry per cycle; the next request can be taken in the cycle
// after the result step
// synchronous active-low reset empties the table, disarms all and clears the handler mark;
// no request is taken while reset is held
// the result waits in an output register; the next request is taken meanwhile,
// and only its own result step stalls while the previous result is still held
module deadline_timer_table import dtt_pkg::*; #(
    parameter int unsigned MAX_SLOTS = MaxSlotsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtt_req_if.sink   i_req,
    dtt_rsp_if.source o_rsp
);

    // control word from the microprogram and flags back from the datapath
    t_uword  uword;
    t_status status;

    // microprogram: wait for request, set up scan, scan slots, apply and post result
    dtt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uword)
    );

    // slot memories, armed flags, handler mark and the result register
    dtt_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .i_uword  (uword),
        .o_status (status)
    );

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for deadline_timer_table, a directed table then random requests
// checked against a cycle-free shadow of the timer table, with random stalls on both channels
// depends on dtt_pkg, dtt_req_if, dtt_rsp_if and deadline_timer_table from the rtl folder
module tb_top;
    import dtt_pkg::*;

    localparam int unsigned Slots      = MaxSlotsDefault;
    localparam int unsigned NumRandom  = 1700;
    localparam int unsigned DrainWait  = 60;
    localparam int unsigned LongHold   = 300;
    localparam int unsigned RunLimit   = 2_000_000;

    typedef struct packed {
        logic [FuncW-1:0] func;
        logic [TagW-1:0]  tag;
        logic [TimeW-1:0] tv;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [TagW-1:0]  fired;
        logic [TimeW-1:0] rtime;
    } t_reply;

    // one directed row: typed rows carry a reply read straight off the spec
    typedef struct packed {
        t_req   req;
        bit     typed;
        t_reply reply;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dtt_req_if req_ch();
    dtt_rsp_if rsp_ch();

    deadline_timer_table #(
        .MAX_SLOTS(Slots)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the timer table
    logic [TagW-1:0]  shadow_tag      [Slots];
    logic [TimeW-1:0] shadow_deadline [Slots];
    bit               shadow_armed    [Slots];
    int unsigned      shadow_used;
    logic [TimeW-1:0] shadow_dispatch;
    bit               shadow_in_handler;

    t_reply      awaited_replies[$];
    int unsigned mismatches;

    // stimulus-side knobs shared with the response side
    bit          quiet_phase;
    bit          long_hold_due;
    logic [TimeW-1:0] sim_now;

    task automatic note_mismatch(input string what, input logic [TimeW-1:0] got,
                                 input logic [TimeW-1:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // slot holding the tag among registered slots, or -1 when absent
    function automatic int slot_of(input logic [TagW-1:0] t);
        for (int i = 0; i < int'(shadow_used); i++)
            if (shadow_tag[i] == t)
                return i;
        return -1;
    endfunction

    // applies one request to the shadow table and returns the reply it gives
    function automatic t_reply timer_table_outcome(input t_req r);
        t_reply rep;
        int     at;
        rep = '0;
        case (r.func)
            FN_REGISTER: begin
                if (shadow_used < Slots && slot_of(r.tag) < 0) begin
                    shadow_tag[shadow_used]      = r.tag;
                    shadow_deadline[shadow_used] = '0;
                    shadow_armed[shadow_used]    = 1'b0;
                    shadow_used++;
                    rep.ok = 1'b1;
                end
            end
            FN_ARM: begin
                at = slot_of(r.tag);
                // inside a handler nothing may be armed at or before the fired deadline
                if (at >= 0 && !(shadow_in_handler && r.tv <= shadow_dispatch)) begin
                    shadow_deadline[at] = r.tv;
                    shadow_armed[at]    = 1'b1;
                    rep.ok              = 1'b1;
                end
            end
            FN_DISARM: begin
                at = slot_of(r.tag);
                if (at >= 0) begin
                    shadow_armed[at] = 1'b0;
                    rep.ok           = 1'b1;
                end
            end
            FN_DISARM_ALL: begin
                for (int i = 0; i < int'(shadow_used); i++)
                    shadow_armed[i] = 1'b0;
                rep.ok = 1'b1;
            end
            FN_QUERY: begin
                at        = slot_of(r.tag);
                rep.ok    = 1'b1;
                rep.rtime = (at >= 0 && shadow_armed[at]) ? shadow_deadline[at] : NEVER_TIME;
            end
            FN_SOONEST: begin
                rep.ok    = 1'b1;
                rep.rtime = NEVER_TIME;
                for (int i = 0; i < int'(shadow_used); i++)
                    if (shadow_armed[i] && shadow_deadline[i] < rep.rtime)
                        rep.rtime = shadow_deadline[i];
            end
            FN_TAKE: begin
                // the handler mark drops on every take, fired or not
                shadow_in_handler = 1'b0;
                at = -1;
                for (int i = 0; i < int'(shadow_used); i++) begin
                    if (shadow_armed[i] && shadow_deadline[i] <= r.tv)
                        if (at < 0 || shadow_deadline[i] < shadow_deadline[at])
                            at = i;
                end
                if (at >= 0) begin
                    shadow_armed[at]  = 1'b0;
                    shadow_dispatch   = shadow_deadline[at];
                    shadow_in_handler = 1'b1;
                    rep.ok            = 1'b1;
                    rep.fired         = shadow_tag[at];
                    rep.rtime         = shadow_deadline[at];
                end else begin
                    rep.rtime = NEVER_TIME;
                end
            end
            default: begin
                // reserved code: no change, all-zero reply
            end
        endcase
        return rep;
    endfunction

    // mostly tags already in the table so that arm, disarm and query do real work
    function automatic logic [TagW-1:0] pick_tag();
        if (shadow_used > 0 && $urandom_range(0, 9) < 8)
            return shadow_tag[$urandom_range(0, shadow_used - 1)];
        return TagW'($urandom_range(0, 255));
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned k;
        int unsigned c;
        r.tv  = {$urandom, $urandom};
        r.tag = pick_tag();
        k     = $urandom_range(0, 99);
        c     = $urandom_range(0, 19);
        if (shadow_used < Slots && $urandom_range(0, 3) == 0) begin
            r.func = FN_REGISTER;
            r.tag  = TagW'($urandom_range(0, 255));
        end else if (k < 4) r.func = FN_REGISTER;
        else if (k < 34) r.func = FN_ARM;
        else if (k < 42) r.func = FN_DISARM;
        else if (k < 44) r.func = FN_DISARM_ALL;
        else if (k < 58) r.func = FN_QUERY;
        else if (k < 68) r.func = FN_SOONEST;
        else if (k < 97) r.func = FN_TAKE;
        else r.func = FN_RESERVED;

        // deadlines cluster just ahead of the running clock, takes sit on it
        if (r.func == FN_ARM) begin
            if (c < 14)
                r.tv = sim_now + $urandom_range(0, 60);
            else if (c < 16)
                r.tv = shadow_dispatch + $urandom_range(0, 2) - 1;
            else if (c == 19)
                r.tv = $urandom_range(0, 1) ? NEVER_TIME : '0;
        end else if (r.func == FN_TAKE) begin
            if (c < 17)
                r.tv = sim_now;
            else if (c == 19)
                r.tv = NEVER_TIME;
        end
        sim_now += $urandom_range(0, 8);
        return r;
    endfunction

    // offers one request until taken, then records the reply it should give
    task automatic offer(input t_req r, input bit typed, input t_reply fixed);
        t_reply predicted;
        req_ch.valid      <= 1'b1;
        req_ch.func       <= r.func;
        req_ch.tag        <= r.tag;
        req_ch.time_value <= r.tv;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = timer_table_outcome(r);
        awaited_replies.push_back(typed ? fixed : predicted);
    endtask

    task automatic maybe_pause();
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // response side: random stalls, one long hold-off when asked for
    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LongHold) @(posedge i_clk);
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // reply checker: every reply taken is matched against the oldest request outcome
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_replies.size() == 0) begin
                note_mismatch("unexpected reply", rsp_ch.result_time, '0);
            end else begin
                want = awaited_replies.pop_front();
                if (rsp_ch.ok !== want.ok)
                    note_mismatch("ok", TimeW'(rsp_ch.ok), TimeW'(want.ok));
                if (rsp_ch.fired_tag !== want.fired)
                    note_mismatch("fired_tag", TimeW'(rsp_ch.fired_tag), TimeW'(want.fired));
                if (rsp_ch.result_time !== want.rtime)
                    note_mismatch("result_time", rsp_ch.result_time, want.rtime);
            end
        end
    end

    initial begin
        #(RunLimit);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_req r;

        // extremes, error codes, duplicates, handler refusal and the tie on take
        rows = '{
            '{'{FN_QUERY,      8'h05, 64'd0},       1'b1, '{1'b1, 8'h00, NEVER_TIME}},
            '{'{FN_SOONEST,    8'h00, 64'd0},       1'b1, '{1'b1, 8'h00, NEVER_TIME}},
            '{'{FN_TAKE,       8'h00, NEVER_TIME},  1'b1, '{1'b0, 8'h00, NEVER_TIME}},
            '{'{FN_RESERVED,   8'hff, NEVER_TIME},  1'b1, '{1'b0, 8'h00, 64'd0}},
            '{'{FN_DISARM,     8'h00, 64'd0},       1'b1, '{1'b0, 8'h00, 64'd0}},
            '{'{FN_ARM,        8'hff, 64'd100},     1'b1, '{1'b0, 8'h00, 64'd0}},
            '{'{FN_DISARM_ALL, 8'h00, 64'd0},       1'b1, '{1'b1, 8'h00, 64'd0}},
            '{'{FN_REGISTER,   8'h00, 64'd0},       1'b1, '{1'b1, 8'h00, 64'd0}},
            '{'{FN_REGISTER,   8'h00, 64'd0},       1'b1, '{1'b0, 8'h00, 64'd0}},
            '{'{FN_REGISTER,   8'hff, NEVER_TIME},  1'b1, '{1'b1, 8'h00, 64'd0}},
            '{'{FN_REGISTER,   8'h5a, 64'd0},       1'b1, '{1'b1, 8'h00, 64'd0}},
            '{'{FN_QUERY,      8'h00, 64'd0},       1'b1, '{1'b1, 8'h00, NEVER_TIME}},
            '{'{FN_ARM,        8'h00, 64'd0},       1'b1, '{1'b1, 8'h00, 64'd0}},
            '{'{FN_ARM,        8'hff, ~64'd1},      1'b1, '{1'b1, 8'h00, 64'd0}},
            '{'{FN_ARM,        8'h5a, 64'd0},       1'b1, '{1'b1, 8'h00, 64'd0}},
            '{'{FN_QUERY,      8'hff, 64'd0},       1'b0, '0},
            '{'{FN_SOONEST,    8'h00, 64'd0},       1'b0, '0},
            '{'{FN_TAKE,       8'h00, 64'd0},       1'b0, '0},
            '{'{FN_ARM,        8'h00, 64'd0},       1'b1, '{1'b0, 8'h00, 64'd0}},
            '{'{FN_ARM,        8'h00, 64'd1},       1'b0, '0},
            '{'{FN_TAKE,       8'h00, NEVER_TIME},  1'b0, '0},
            '{'{FN_DISARM,     8'hff, 64'd0},       1'b0, '0},
            '{'{FN_TAKE,       8'h00, NEVER_TIME},  1'b0, '0},
            '{'{FN_DISARM_ALL, 8'h00, 64'd0},       1'b1, '{1'b1, 8'h00, 64'd0}},
            '{'{FN_TAKE,       8'h00, NEVER_TIME},  1'b1, '{1'b0, 8'h00, NEVER_TIME}}
        };

        mismatches        = 0;
        quiet_phase       = 1'b0;
        long_hold_due     = 1'b0;
        sim_now           = 64'd1000;
        shadow_used       = 0;
        shadow_dispatch   = '0;
        shadow_in_handler = 1'b0;
        foreach (shadow_armed[i])
            shadow_armed[i] = 1'b0;

        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FN_RESERVED;
        req_ch.tag        <= '0;
        req_ch.time_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            maybe_pause();
            offer(rows[i].req, rows[i].typed, rows[i].reply);
        end

        // random requests; a window in the middle and the tail run without idling
        for (int n = 0; n < int'(NumRandom); n++) begin
            quiet_phase = (n >= 900 && n < 1000) || (n >= int'(NumRandom) - 200);
            if (n == 400)
                long_hold_due = 1'b1;
            maybe_pause();
            r = random_request();
            offer(r, 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        if (mismatches == 0 && awaited_replies.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### filelist.f
rtl/dtt_pkg.sv
rtl/dtt_if.sv
rtl/dtt_seq.sv
rtl/dtt_datapath.sv
rtl/deadline_timer_table.sv
bench/tb_top.sv
